### rtl/core/cpq_pkg.sv
// Shared types, constants and helper functions for the cyclotomic Phi_pq reduction block.
// Self-contained; every other file in rtl/core imports it.
package cpq_pkg;

	// Sizing of the coefficient store and of the coefficient word.
	localparam int MAX_LEN    = 64;
	localparam int MAX_PRIME  = 8;
	localparam int COEFF_BITS = 32;
	localparam int BUF_LEN    = MAX_LEN + 2 * MAX_PRIME;
	localparam int ADDR_W     = $clog2(BUF_LEN);
	localparam int CNT_W      = $clog2(MAX_LEN + 1);
	localparam int BIT_CNT_W  = $clog2(COEFF_BITS);
	localparam int PRIME_W    = 4;
	localparam int DEG_W      = 6;
	localparam int REG_ADDR_W = 4;

	typedef logic [COEFF_BITS-1:0] coeff_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [PRIME_W-1:0]    prime_t;
	typedef logic [DEG_W-1:0]      deg_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Register indexes on the configuration port (word address paddr[3:2]).
	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_PRIME_A = 2'd1;
	localparam logic [1:0] REG_PRIME_B = 2'd2;

	localparam coeff_t MODULUS_RESET = coeff_t'(127);
	localparam prime_t PRIME_A_RESET = prime_t'(3);
	localparam prime_t PRIME_B_RESET = prime_t'(5);
	localparam prime_t MIN_PRIME_P   = prime_t'(2);
	localparam prime_t MAX_PRIME_P   = prime_t'(MAX_PRIME);
	localparam cnt_t   MAX_LEN_C     = cnt_t'(MAX_LEN);

	// Input and output beats.
	typedef struct packed {
		coeff_t coeff_in;
		logic   is_final;
	} in_beat_t;

	typedef struct packed {
		coeff_t coeff_out;
		deg_t   degree_out;
		logic   end_of_run;
		logic   overflow_flag;
	} out_beat_t;

	// Shared modular unit request.
	typedef enum logic [0:0] {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		coeff_t  a;
		coeff_t  b;
		logic    cin;
	} alu_req_t;

	// Coefficient store command from the sequencer.
	typedef struct packed {
		logic   rd_en;
		addr_t  rd_lo;
		addr_t  rd_hi;
		logic   wr_en;
		addr_t  wr_addr;
		coeff_t wr_data;
		logic   clear;
	} mem_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REM,
		ST_STORE,
		ST_SETUP,
		ST_RD,
		ST_OP1,
		ST_OP2,
		ST_EMIT_RD,
		ST_EMIT_PUT,
		ST_CLEAR
	} state_t;

	// The seven in-place passes, in the order they run.
	typedef enum logic [2:0] {
		PASS_MUL_P,
		PASS_MUL_Q,
		PASS_DIV_X1,
		PASS_FOLD,
		PASS_MUL_X1,
		PASS_DIV_Q,
		PASS_DIV_P
	} pass_t;

	typedef enum logic [1:0] {
		KIND_MUL,
		KIND_DIV,
		KIND_FOLD
	} kind_t;

	// Factors below two act as two, above the maximum act as the maximum.
	function automatic prime_t clamp_prime(prime_t v);
		prime_t r;
		r = v;
		if (v < MIN_PRIME_P) r = MIN_PRIME_P;
		else if (v > MAX_PRIME_P) r = MAX_PRIME_P;
		return r;
	endfunction

	// Number of reduced coefficients, (p-1)(q-1), for clamped factors.
	function automatic deg_t reduced_count(prime_t p, prime_t q);
		logic [2*PRIME_W-1:0] prod;
		prod = (p - prime_t'(1)) * (q - prime_t'(1));
		return prod[DEG_W-1:0];
	endfunction

	// A zero modulus acts as modulus one.
	function automatic coeff_t effective_modulus(coeff_t m);
		return (m == '0) ? coeff_t'(1) : m;
	endfunction

endpackage

### rtl/core/cpq_alu.sv
// Shared modular add / subtract unit used for the input remainder and every pass.
// Depends on cpq_pkg for the request type and coefficient width.
module cpq_alu (
	input  cpq_pkg::alu_req_t req,
	input  cpq_pkg::coeff_t   modulus,
	output cpq_pkg::coeff_t   result
);
	import cpq_pkg::*;

	logic [COEFF_BITS:0] sum;
	logic [COEFF_BITS:0] sum_red;
	logic [COEFF_BITS:0] diff;
	coeff_t              diff_fix;

	// Sum with carry in; one conditional subtract brings it below the modulus.
	always_comb begin
		sum     = {1'b0, req.a} + {1'b0, req.b} + {{COEFF_BITS{1'b0}}, req.cin};
		sum_red = sum - {1'b0, modulus};
		diff    = {1'b0, req.a} - {1'b0, req.b};
		diff_fix = diff[COEFF_BITS-1:0] + modulus;
	end

	// Select the add or subtract result; a borrow adds the modulus back.
	always_comb begin
		unique case (req.op)
			ALU_ADD: begin
				result = (sum >= {1'b0, modulus}) ? sum_red[COEFF_BITS-1:0]
					: sum[COEFF_BITS-1:0];
			end
			ALU_SUB: begin
				result = diff[COEFF_BITS] ? diff_fix : diff[COEFF_BITS-1:0];
			end
			default: result = '0;
		endcase
	end

endmodule

### rtl/core/cpq_buf.sv
// Coefficient store: one write port, two registered read ports, per-entry valid bits.
// Depends on cpq_pkg for the command type and sizes.
module cpq_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  cpq_pkg::mem_cmd_t   cmd,
	output cpq_pkg::coeff_t     lo_data,
	output cpq_pkg::coeff_t     hi_data
);
	import cpq_pkg::*;

	coeff_t             mem [BUF_LEN];
	logic [BUF_LEN-1:0] valid_q;
	coeff_t             lo_data_q;
	coeff_t             hi_data_q;
	logic               lo_vld_q;
	logic               hi_vld_q;

	// Storage array and read data registers.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			lo_data_q <= mem[cmd.rd_lo];
			hi_data_q <= mem[cmd.rd_hi];
		end
	end

	// Valid bits: an entry never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			lo_vld_q <= 1'b0;
			hi_vld_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (cmd.wr_en) begin
				valid_q[cmd.wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				lo_vld_q <= valid_q[cmd.rd_lo];
				hi_vld_q <= valid_q[cmd.rd_hi];
			end
		end
	end

	assign lo_data = lo_vld_q ? lo_data_q : '0;
	assign hi_data = hi_vld_q ? hi_data_q : '0;

endmodule

### rtl/core/cpq_seq.sv
// Sequencer: loads coefficients, runs the seven passes on the shared unit, emits results.
// Depends on cpq_pkg; drives cpq_buf and cpq_alu through command structs.
module cpq_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cpq_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output cpq_pkg::out_beat_t  out_data,
	input  cpq_pkg::prime_t     prime_p,
	input  cpq_pkg::prime_t     prime_q,
	output cpq_pkg::mem_cmd_t   mem_cmd,
	input  cpq_pkg::coeff_t     lo_data,
	input  cpq_pkg::coeff_t     hi_data,
	output cpq_pkg::alu_req_t   alu_req,
	input  cpq_pkg::coeff_t     alu_res
);
	import cpq_pkg::*;

	state_t    state_q, state_d;
	pass_t     pass_q, pass_nx;
	kind_t     kind_q, kind_s;
	addr_t     k_q, k_s;
	addr_t     ptr_q, ptr_s;
	addr_t     iter_q, iter_s;
	coeff_t    coeff_sh_q;
	coeff_t    rem_q;
	logic [BIT_CNT_W-1:0] bit_q;
	logic      final_q;
	cnt_t      load_cnt_q;
	logic      ovf_q;
	deg_t      emit_q;
	logic      out_valid_q;
	out_beat_t out_data_q;

	addr_t              len_w;
	logic [2*PRIME_W-1:0] pq_w;
	addr_t              addr_lo;
	addr_t              addr_hi;
	deg_t               n_w;
	logic               emit_last;
	logic               out_free;
	logic               out_load;
	logic               last_pass;

	// Per-run lengths from the stored count and the clamped factors.
	always_comb begin
		len_w     = addr_t'(load_cnt_q) + addr_t'(prime_p) + addr_t'(prime_q);
		pq_w      = prime_p * prime_q;
		n_w       = reduced_count(prime_p, prime_q);
		emit_last = (emit_q == n_w - deg_t'(1));
		out_free  = !out_valid_q || !out_stall;
		out_load  = (state_q == ST_EMIT_PUT) && out_free;
		last_pass = (pass_q == PASS_DIV_P);
	end

	// Pass table: kind, offset, iteration count and start pointer.
	always_comb begin
		kind_s  = KIND_MUL;
		k_s     = addr_t'(prime_p);
		iter_s  = len_w - addr_t'(prime_p);
		pass_nx = PASS_MUL_P;
		unique case (pass_q)
			PASS_MUL_P: begin
				kind_s  = KIND_MUL;
				k_s     = addr_t'(prime_p);
				iter_s  = len_w - addr_t'(prime_p);
				pass_nx = PASS_MUL_Q;
			end
			PASS_MUL_Q: begin
				kind_s  = KIND_MUL;
				k_s     = addr_t'(prime_q);
				iter_s  = len_w - addr_t'(prime_q);
				pass_nx = PASS_DIV_X1;
			end
			PASS_DIV_X1: begin
				kind_s  = KIND_DIV;
				k_s     = addr_t'(1);
				iter_s  = len_w - addr_t'(1);
				pass_nx = PASS_FOLD;
			end
			PASS_FOLD: begin
				kind_s  = KIND_FOLD;
				k_s     = addr_t'(pq_w);
				iter_s  = ({1'b0, len_w} > {1'b0, pq_w}) ? len_w - addr_t'(pq_w) : '0;
				pass_nx = PASS_MUL_X1;
			end
			PASS_MUL_X1: begin
				kind_s  = KIND_MUL;
				k_s     = addr_t'(1);
				iter_s  = len_w - addr_t'(1);
				pass_nx = PASS_DIV_Q;
			end
			PASS_DIV_Q: begin
				kind_s  = KIND_DIV;
				k_s     = addr_t'(prime_q);
				iter_s  = addr_t'(load_cnt_q) + addr_t'(prime_p);
				pass_nx = PASS_DIV_P;
			end
			PASS_DIV_P: begin
				kind_s  = KIND_DIV;
				k_s     = addr_t'(prime_p);
				iter_s  = addr_t'(load_cnt_q) + addr_t'(prime_q);
				pass_nx = PASS_DIV_P;
			end
			default: begin
				kind_s  = KIND_MUL;
				k_s     = addr_t'(prime_p);
				iter_s  = '0;
				pass_nx = PASS_DIV_P;
			end
		endcase
		ptr_s = (kind_s == KIND_DIV) ? '0 : len_w - addr_t'(1);
	end

	// Division passes walk upward from the low entry, the others downward from the high one.
	always_comb begin
		if (kind_q == KIND_DIV) begin
			addr_lo = ptr_q;
			addr_hi = ptr_q + k_q;
		end else begin
			addr_lo = ptr_q - k_q;
			addr_hi = ptr_q;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, store commands and shared unit requests.
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mem_cmd  = '0;
		alu_req  = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_REM;
			end
			ST_REM: begin
				// One restoring step per cycle: rem = 2*rem + next bit, reduced.
				alu_req.op  = ALU_ADD;
				alu_req.a   = rem_q;
				alu_req.b   = rem_q;
				alu_req.cin = coeff_sh_q[COEFF_BITS-1];
				if (bit_q == BIT_CNT_W'(COEFF_BITS - 1)) state_d = ST_STORE;
			end
			ST_STORE: begin
				if (load_cnt_q < MAX_LEN_C) begin
					mem_cmd.wr_en   = 1'b1;
					mem_cmd.wr_addr = addr_t'(load_cnt_q);
					mem_cmd.wr_data = rem_q;
				end
				state_d = final_q ? ST_SETUP : ST_IDLE;
			end
			ST_SETUP: begin
				if (iter_s != '0) state_d = ST_RD;
				else if (last_pass) state_d = ST_EMIT_RD;
			end
			ST_RD: begin
				mem_cmd.rd_en = 1'b1;
				mem_cmd.rd_lo = addr_lo;
				mem_cmd.rd_hi = addr_hi;
				state_d = ST_OP1;
			end
			ST_OP1: begin
				mem_cmd.wr_en   = 1'b1;
				mem_cmd.wr_data = alu_res;
				unique case (kind_q)
					KIND_MUL: begin
						mem_cmd.wr_addr = addr_hi;
						alu_req.op = ALU_ADD;
						alu_req.a  = hi_data;
						alu_req.b  = lo_data;
					end
					KIND_DIV: begin
						mem_cmd.wr_addr = addr_lo;
						alu_req.op = ALU_SUB;
						alu_req.b  = lo_data;
					end
					KIND_FOLD: begin
						mem_cmd.wr_addr = addr_lo;
						alu_req.op = ALU_ADD;
						alu_req.a  = lo_data;
						alu_req.b  = hi_data;
					end
					default: mem_cmd.wr_en = 1'b0;
				endcase
				state_d = ST_OP2;
			end
			ST_OP2: begin
				mem_cmd.wr_en   = 1'b1;
				mem_cmd.wr_data = alu_res;
				unique case (kind_q)
					KIND_MUL: begin
						// Negate the old low entry.
						mem_cmd.wr_addr = addr_lo;
						alu_req.op = ALU_SUB;
						alu_req.b  = lo_data;
					end
					KIND_DIV: begin
						// Subtracting the negated low entry adds the old one.
						mem_cmd.wr_addr = addr_hi;
						alu_req.op = ALU_ADD;
						alu_req.a  = hi_data;
						alu_req.b  = lo_data;
					end
					KIND_FOLD: begin
						// Folded high entry becomes zero.
						mem_cmd.wr_addr = addr_hi;
						alu_req.op = ALU_SUB;
					end
					default: mem_cmd.wr_en = 1'b0;
				endcase
				if (iter_q == addr_t'(1)) state_d = last_pass ? ST_EMIT_RD : ST_SETUP;
				else state_d = ST_RD;
			end
			ST_EMIT_RD: begin
				mem_cmd.rd_en = 1'b1;
				mem_cmd.rd_lo = addr_t'(emit_q);
				mem_cmd.rd_hi = addr_t'(emit_q);
				state_d = ST_EMIT_PUT;
			end
			ST_EMIT_PUT: begin
				if (out_free) state_d = emit_last ? ST_CLEAR : ST_EMIT_RD;
			end
			ST_CLEAR: begin
				mem_cmd.clear = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q       <= '0;
			final_q     <= 1'b0;
			load_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			pass_q      <= PASS_MUL_P;
			iter_q      <= '0;
			emit_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						final_q <= in_data.is_final;
						bit_q   <= '0;
					end
				end
				ST_REM: bit_q <= bit_q + BIT_CNT_W'(1);
				ST_STORE: begin
					if (load_cnt_q < MAX_LEN_C) load_cnt_q <= load_cnt_q + cnt_t'(1);
					else ovf_q <= 1'b1;
					pass_q <= PASS_MUL_P;
					emit_q <= '0;
				end
				ST_SETUP: begin
					iter_q <= iter_s;
					if (iter_s == '0) pass_q <= pass_nx;
				end
				ST_OP2: begin
					iter_q <= iter_q - addr_t'(1);
					if (iter_q == addr_t'(1)) pass_q <= pass_nx;
				end
				ST_EMIT_PUT: begin
					if (out_free) begin
						emit_q <= emit_q + deg_t'(1);
					end
				end
				ST_CLEAR: begin
					load_cnt_q <= '0;
					ovf_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Output register valid: set when a result is loaded, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					coeff_sh_q <= in_data.coeff_in;
					rem_q      <= '0;
				end
			end
			ST_REM: begin
				rem_q      <= alu_res;
				coeff_sh_q <= coeff_sh_q << 1;
			end
			ST_SETUP: begin
				kind_q <= kind_s;
				k_q    <= k_s;
				ptr_q  <= ptr_s;
			end
			ST_OP2: begin
				ptr_q <= (kind_q == KIND_DIV) ? ptr_q + addr_t'(1) : ptr_q - addr_t'(1);
			end
			ST_EMIT_PUT: begin
				if (out_free) begin
					out_data_q.coeff_out     <= lo_data;
					out_data_q.degree_out    <= emit_q;
					out_data_q.end_of_run    <= emit_last;
					out_data_q.overflow_flag <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/core/cyclotomic_pq_reduction.sv
// Reduction of a polynomial modulo the cyclotomic Phi_pq, with an APB-style register port.
// Depends on cpq_pkg; instantiates cpq_alu, cpq_buf and cpq_seq.
// Each coefficient beat is accepted, then runs 32 bit-serial remainder steps on the shared
// modular unit and is stored. After the final beat each pass has a setup step, then each
// coefficient step reads the store and writes two entries; each result beat is a store read
// then an output load, and a clear step ends the run. Reset empties the store.
module cyclotomic_pq_reduction (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpq_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cpq_pkg::in_beat_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cpq_pkg::out_beat_t            out_data
);
	import cpq_pkg::*;

	coeff_t   modulus_q;
	prime_t   prime_a_q;
	prime_t   prime_b_q;
	coeff_t   modulus_eff;
	prime_t   prime_p;
	prime_t   prime_q;
	logic     reg_wr;
	mem_cmd_t mem_cmd;
	coeff_t   lo_data;
	coeff_t   hi_data;
	alu_req_t alu_req;
	coeff_t   alu_res;

	// Register writes complete in the access cycle.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			prime_a_q <= PRIME_A_RESET;
			prime_b_q <= PRIME_B_RESET;
		end else if (reg_wr) begin
			unique case (paddr[3:2])
				REG_MODULUS: modulus_q <= pwdata;
				REG_PRIME_A: prime_a_q <= pwdata[PRIME_W-1:0];
				REG_PRIME_B: prime_b_q <= pwdata[PRIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			REG_MODULUS: prdata = modulus_q;
			REG_PRIME_A: prdata = {{(32 - PRIME_W){1'b0}}, prime_a_q};
			REG_PRIME_B: prdata = {{(32 - PRIME_W){1'b0}}, prime_b_q};
			default:     prdata = '0;
		endcase
	end

	// Effective arithmetic settings.
	assign modulus_eff = effective_modulus(modulus_q);
	assign prime_p     = clamp_prime(prime_a_q);
	assign prime_q     = clamp_prime(prime_b_q);

	cpq_alu u_alu (
		.req     (alu_req),
		.modulus (modulus_eff),
		.result  (alu_res)
	);

	cpq_buf u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mem_cmd),
		.lo_data (lo_data),
		.hi_data (hi_data)
	);

	cpq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.prime_p   (prime_p),
		.prime_q   (prime_q),
		.mem_cmd   (mem_cmd),
		.lo_data   (lo_data),
		.hi_data   (hi_data),
		.alu_req   (alu_req),
		.alu_res   (alu_res)
	);

	// An accepted beat keeps the block busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a beat");

	// The store is never read and written in the same cycle by the schedule.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_cmd.rd_en && mem_cmd.wr_en))
		else $error("store read and write collide");

	// The last result of a run carries degree (p-1)(q-1)-1.
	a_last_degree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_of_run |->
		out_data.degree_out == reduced_count(prime_p, prime_q) - deg_t'(1))
		else $error("end of run on the wrong degree");

endmodule
